// ----- design/anemometer_vane_processor_top_macros.svh -----
// ----------------------------------------------------------------------------
// Anemometer vane processor assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ANEMOMETER_VANE_PROCESSOR_TOP_MACROS_SVH
`define ANEMOMETER_VANE_PROCESSOR_TOP_MACROS_SVH

// Same-cycle implication.
`define AVP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define AVP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/avp_pkg.sv -----
// ----------------------------------------------------------------------------
// Anemometer vane processor package
// Field widths, vane range table, queue entry type and register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package avp_pkg;

   localparam int COUNT_W   = 16;
   localparam int ADC_W     = 12;
   localparam int GAIN_W    = 10;
   localparam int FRAC_BITS = 6;
   localparam int SPEED_W   = COUNT_W + GAIN_W - FRAC_BITS;
   localparam int OUT_W     = 16;
   localparam int DIR_W     = 4;
   localparam int TABLE_SIZE = 16;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd553;
   localparam logic [OUT_W-1:0]  OUT_MAX    = 16'hFFFF;

   // Inclusive ADC ranges of the vane, one row per compass point.
   localparam logic [ADC_W-1:0] VANE_LO [TABLE_SIZE] = '{
      12'd2970, 12'd1567, 12'd1773, 12'd320, 12'd360, 12'd245, 12'd728, 12'd496,
      12'd1120, 12'd957,  12'd2390, 12'd2280, 12'd3549, 12'd3117, 12'd3340, 12'd2660
   };
   localparam logic [ADC_W-1:0] VANE_HI [TABLE_SIZE] = '{
      12'd3010, 12'd1607, 12'd1813, 12'd360, 12'd400, 12'd285, 12'd768, 12'd536,
      12'd1160, 12'd997,  12'd2430, 12'd2320, 12'd3589, 12'd3157, 12'd3380, 12'd2700
   };

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_ADDR = 2'd0;

   // One classified measurement on its way from front to back.
   typedef struct packed {
      logic [COUNT_W-1:0] pulse_count;
      logic [DIR_W-1:0]   direction;
      logic               direction_miss;
   } queue_item_type;

endpackage

// ----- design/anemometer_vane_processor_top.sv -----
// ----------------------------------------------------------------------------
// Anemometer vane processor
// Moving average and peak of scaled anemometer counts, plus wind vane decode.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   req_      in         req_valid / req_stall      req_pulse_count, req_vane_adc
//   rsp_      out        rsp_valid / rsp_stall      rsp_avg_speed, rsp_max_speed,
//                                                   rsp_direction, rsp_direction_miss
//   APB       in/out     psel, penable, pready      paddr, pwrite, pwdata, prdata
//
// The front end takes a transaction, walks the vane table one row per cycle
// and hands the item to the queue. The back end walks every ring entry
// through its single read port, which visits one entry a cycle. The queue
// lets the front end take a new transaction before the back end is through
// with the last one.
// Reset is synchronous and active high; it clears the ring through its valid
// bits and restores the speed gain to 553.
// A stalled result waits in the output register while the back end goes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anemometer_vane_processor_top #(
   parameter int WINDOW_DEPTH   = 8,
   parameter int DIRECTION_ROWS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Measurement transactions.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [avp_pkg::COUNT_W-1:0]      req_pulse_count,
   input  logic [avp_pkg::ADC_W-1:0]        req_vane_adc,
   // Result transactions.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [avp_pkg::OUT_W-1:0]        rsp_avg_speed,
   output logic [avp_pkg::OUT_W-1:0]        rsp_max_speed,
   output logic [avp_pkg::DIR_W-1:0]        rsp_direction,
   output logic                             rsp_direction_miss,
   // Register access.
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [avp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [avp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [avp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import avp_pkg::*;

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              gain_write;

   logic              push;
   queue_item_type    push_item;
   logic              full;
   logic              pop;
   queue_item_type    pop_item;
   logic              empty;

   // The register port never waits; the gain register sits at byte zero.
   assign pready     = 1'b1;
   assign gain_write = psel && penable && pwrite && (paddr == CSR_GAIN_ADDR);
   assign gain_in    = gain_write ? pwdata[GAIN_W-1:0] : gain_ff;
   assign prdata     = (paddr == CSR_GAIN_ADDR) ? CSR_DATA_W'(gain_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // Front end: accepts the measurement and finds its compass point.
   avp_front #(
      .DIRECTION_ROWS(DIRECTION_ROWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pulse_count (req_pulse_count),
      .req_vane_adc    (req_vane_adc),
      .push            (push),
      .push_item       (push_item),
      .full            (full)
   );

   // The queue lets the front end classify the next measurement while the
   // back end is still walking the window for the previous one.
   avp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   // Back end: updates the ring, computes average and peak, owns the result.
   avp_back #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .speed_gain         (gain_ff),
      .empty              (empty),
      .pop_item           (pop_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_avg_speed      (rsp_avg_speed),
      .rsp_max_speed      (rsp_max_speed),
      .rsp_direction      (rsp_direction),
      .rsp_direction_miss (rsp_direction_miss)
   );

endmodule

// ----- design/avp_front.sv -----
// ----------------------------------------------------------------------------
// Anemometer vane processor front end
// Accepts a measurement and walks the vane table one row per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avp_front #(
   parameter int DIRECTION_ROWS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [avp_pkg::COUNT_W-1:0]   req_pulse_count,
   input  logic [avp_pkg::ADC_W-1:0]     req_vane_adc,
   output logic                          push,
   output avp_pkg::queue_item_type       push_item,
   input  logic                          full
);
   import avp_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_SCAN, F_PUSH} front_state_type;

   localparam logic [DIR_W-1:0] LAST_ROW = DIR_W'(DIRECTION_ROWS - 1);

   front_state_type    state_ff, state_in;
   logic [DIR_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADC_W-1:0]   adc_ff, adc_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic               miss_ff, miss_in;
   logic               hit;

   assign hit       = (adc_ff >= VANE_LO[row_ff]) && (adc_ff <= VANE_HI[row_ff]);
   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH) && !full;

   assign push_item.pulse_count    = count_ff;
   assign push_item.direction      = dir_ff;
   assign push_item.direction_miss = miss_ff;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      count_in = count_ff;
      adc_in   = adc_ff;
      dir_in   = dir_ff;
      miss_in  = miss_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               count_in = req_pulse_count;
               adc_in   = req_vane_adc;
               row_in   = '0;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (hit) begin
               dir_in   = row_ff;
               miss_in  = 1'b0;
               state_in = F_PUSH;
            end else if (row_ff == LAST_ROW) begin
               // No range held the reading: report north and flag it.
               dir_in   = '0;
               miss_in  = 1'b1;
               state_in = F_PUSH;
            end else begin
               row_in = row_ff + DIR_W'(1);
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         count_ff <= count_in;
         adc_ff   <= adc_in;
         dir_ff   <= dir_in;
         miss_ff  <= miss_in;
      end
   end

endmodule

// ----- design/avp_queue.sv -----
// ----------------------------------------------------------------------------
// Anemometer vane processor queue
// Short first-in first-out buffer of classified measurements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  avp_pkg::queue_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output avp_pkg::queue_item_type pop_item,
   output logic                    empty
);
   import avp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_item_type   entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- design/avp_back.sv -----
// ----------------------------------------------------------------------------
// Anemometer vane processor back end
// Writes the count ring, walks it through a multiply stage and accumulates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "anemometer_vane_processor_top_macros.svh"

module avp_back #(
   parameter int WINDOW_DEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [avp_pkg::GAIN_W-1:0]  speed_gain,
   input  logic                        empty,
   input  avp_pkg::queue_item_type     pop_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [avp_pkg::OUT_W-1:0]   rsp_avg_speed,
   output logic [avp_pkg::OUT_W-1:0]   rsp_max_speed,
   output logic [avp_pkg::DIR_W-1:0]   rsp_direction,
   output logic                        rsp_direction_miss
);
   import avp_pkg::*;

   typedef enum logic [1:0] {B_IDLE, B_READ, B_DRAIN, B_DONE} back_state_type;

   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int SHIFT  = $clog2(WINDOW_DEPTH + 1) - 1;
   localparam int SUM_W  = SPEED_W + AW;
   localparam int PROD_W = COUNT_W + GAIN_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

   back_state_type       state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [WINDOW_DEPTH-1:0] valid_ff, valid_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 rd_ok_ff;
   logic                 mul_vld_ff, mul_vld_in;
   logic [SPEED_W-1:0]   speed_ff, speed_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SPEED_W-1:0]   max_ff, max_in;
   logic [DIR_W-1:0]     dir_ff, dir_in;
   logic                 miss_ff, miss_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_avg_ff, rsp_avg_in;
   logic [OUT_W-1:0]     rsp_max_ff, rsp_max_in;
   logic [DIR_W-1:0]     rsp_dir_ff, rsp_dir_in;
   logic                 rsp_miss_ff, rsp_miss_in;

   logic [COUNT_W-1:0]   ring_mem [WINDOW_DEPTH];
   logic [COUNT_W-1:0]   rd_data_ff;
   logic [COUNT_W-1:0]   rd_word;
   logic [PROD_W-1:0]    prod;
   logic [SUM_W-1:0]     avg_full;
   logic                 out_load;

   assign pop      = (state_ff == B_IDLE) && !empty;
   assign out_load = (state_ff == B_DONE) && (!rsp_valid_ff || !rsp_stall);
   // An entry never written since reset reads as zero.
   assign rd_word  = rd_ok_ff ? rd_data_ff : '0;
   assign prod     = PROD_W'(rd_word) * PROD_W'(speed_gain);
   assign avg_full = sum_ff >> SHIFT;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_avg_speed      = rsp_avg_ff;
   assign rsp_max_speed      = rsp_max_ff;
   assign rsp_direction      = rsp_dir_ff;
   assign rsp_direction_miss = rsp_miss_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         ring_mem[head_ff] <= pop_item.pulse_count;
      end
      rd_data_ff <= ring_mem[rd_idx_ff];
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      valid_in    = valid_ff;
      rd_idx_in   = rd_idx_ff;
      rd_vld_in   = 1'b0;
      mul_vld_in  = rd_vld_ff;
      speed_in    = prod[PROD_W-1:FRAC_BITS];
      sum_in      = sum_ff;
      max_in      = max_ff;
      dir_in      = dir_ff;
      miss_in     = miss_ff;
      rsp_avg_in  = rsp_avg_ff;
      rsp_max_in  = rsp_max_ff;
      rsp_dir_in  = rsp_dir_ff;
      rsp_miss_in = rsp_miss_ff;

      if (mul_vld_ff) begin
         sum_in = sum_ff + SUM_W'(speed_ff);
         if (speed_ff > max_ff) begin
            max_in = speed_ff;
         end
      end

      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               valid_in[head_ff] = 1'b1;
               head_in   = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
               dir_in    = pop_item.direction;
               miss_in   = pop_item.direction_miss;
               sum_in    = '0;
               max_in    = '0;
               rd_idx_in = '0;
               state_in  = B_READ;
            end
         end
         B_READ: begin
            rd_vld_in = 1'b1;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = B_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + AW'(1);
            end
         end
         B_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_avg_in  = (avg_full > SUM_W'(OUT_MAX)) ? OUT_MAX : avg_full[OUT_W-1:0];
               rsp_max_in  = (max_ff > SPEED_W'(OUT_MAX)) ? OUT_MAX : max_ff[OUT_W-1:0];
               rsp_dir_in  = dir_ff;
               rsp_miss_in = miss_ff;
               state_in    = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         head_ff      <= '0;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         rd_ok_ff     <= valid_ff[rd_idx_ff];
         mul_vld_ff   <= mul_vld_in;
         speed_ff     <= speed_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         dir_ff       <= dir_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_avg_ff   <= rsp_avg_in;
         rsp_max_ff   <= rsp_max_in;
         rsp_dir_ff   <= rsp_dir_in;
         rsp_miss_ff  <= rsp_miss_in;
      end
   end

   `AVP_ASSERT_NEXT(a_head_step, pop, head_ff == (($past(head_ff) == LAST_IDX) ? '0 : $past(head_ff) + AW'(1)), "ring head did not advance by one after a pop")
   `AVP_ASSERT_NEXT(a_entry_valid, pop, valid_ff[$past(head_ff)], "written ring entry not marked valid")
   `AVP_ASSERT_IMPL(a_mul_order, mul_vld_ff, $past(rd_vld_ff), "multiply stage ran without a preceding read")

endmodule
